// ----- sv/utf8d_pkg.sv -----
// package: word types, status codes and sequence helpers for the utf-8 decoder
`default_nettype none
package utf8d_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SURR    = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_ILLEGAL = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [31:0] MAX_SCALAR  = 32'h0010FFFF;
    localparam logic [31:0] SUR_LO      = 32'h0000D800;
    localparam logic [31:0] SUR_HI      = 32'h0000DFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  status;
        logic        buffer_end;
    } t_out_word;

    typedef enum logic [1:0] {
        K_DECODE  = 2'd0,
        K_ILLEGAL = 2'd1,
        K_TRUNC   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  len_idx;
        t_kind       kind;
        logic        strict;
        logic        eob;
    } t_seq;

    function automatic logic [2:0] trail_count(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'hC0)      n = 3'd0;
        else if (b < 8'hE0) n = 3'd1;
        else if (b < 8'hF0) n = 3'd2;
        else if (b < 8'hF8) n = 3'd3;
        else if (b < 8'hFC) n = 3'd4;
        else                n = 3'd5;
        return n;
    endfunction

    function automatic logic [31:0] len_offset(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h00000000;
            3'd1: v = 32'h00003080;
            3'd2: v = 32'h000E2080;
            3'd3: v = 32'h03C82080;
            3'd4: v = 32'hFA082080;
            3'd5: v = 32'h82082080;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- sv/utf8d_front.sv -----
// front: accepts bytes, gathers sequences, checks legality and queues completed or truncated ones
`default_nettype none
module utf8d_front
    import utf8d_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_accept,
    input  wire t_in_word i_in_word,
    output logic          o_seq_push,
    output t_seq          o_seq
);

    logic        r_strict;
    logic        r_halted, n_halted;
    logic [2:0]  r_held, n_held;
    logic [2:0]  r_needed, n_needed;
    logic [31:0] r_acc, n_acc;
    logic        r_ok, n_ok;
    logic [7:0]  r_lead, n_lead;

    logic [7:0]  b;
    logic        eob;
    logic        byte_ok;
    logic [2:0]  held_inc;

    assign b        = i_in_word.data_byte;
    assign eob      = i_in_word.end_of_buffer;
    assign held_inc = r_held + 3'd1;

    always_comb begin
        byte_ok = (b >= 8'h80) && (b <= 8'hBF);
        if (r_held == 3'd1) begin
            case (r_lead)
                8'hE0: byte_ok = (b >= 8'hA0) && (b <= 8'hBF);
                8'hED: byte_ok = (b <= 8'h9F);
                8'hF0: byte_ok = (b >= 8'h90) && (b <= 8'hBF);
                8'hF4: byte_ok = (b <= 8'h8F);
                default: byte_ok = (b >= 8'h80) && (b <= 8'hBF);
            endcase
        end
    end

    always_comb begin
        n_halted    = r_halted;
        n_held      = r_held;
        n_needed    = r_needed;
        n_acc       = r_acc;
        n_ok        = r_ok;
        n_lead      = r_lead;
        o_seq_push  = 1'b0;
        o_seq.acc     = n_acc;
        o_seq.len_idx = r_needed - 3'd1;
        o_seq.kind    = K_DECODE;
        o_seq.strict  = r_strict;
        o_seq.eob     = eob;
        if (i_accept) begin
            if (r_halted) begin
                if (eob) begin
                    n_halted = 1'b0;
                    n_held   = 3'd0;
                    n_needed = 3'd0;
                end
            end else begin
                if (r_held == 3'd0) begin
                    n_lead   = b;
                    n_needed = trail_count(b) + 3'd1;
                    n_acc    = {24'd0, b};
                    n_ok     = (b < 8'h80) || ((b >= 8'hC2) && (b <= 8'hF4));
                    n_held   = 3'd1;
                end else begin
                    n_acc  = {r_acc[25:0], 6'd0} + {24'd0, b};
                    n_ok   = r_ok && byte_ok;
                    n_held = held_inc;
                end
                o_seq.acc     = n_acc;
                o_seq.len_idx = n_needed - 3'd1;
                if (n_held != n_needed) begin
                    if (eob) begin
                        n_held      = 3'd0;
                        n_needed    = 3'd0;
                        o_seq_push  = 1'b1;
                        o_seq.kind  = K_TRUNC;
                    end
                end else begin
                    n_held     = 3'd0;
                    n_needed   = 3'd0;
                    o_seq_push = 1'b1;
                    if (r_strict && !n_ok) begin
                        o_seq.kind = K_ILLEGAL;
                        n_halted   = !eob;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
            r_halted <= 1'b0;
            r_held   <= 3'd0;
            r_needed <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                r_strict <= i_cfg_wdata;
            end
            r_halted <= n_halted;
            r_held   <= n_held;
            r_needed <= n_needed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_ok   <= n_ok;
        r_lead <= n_lead;
    end

endmodule
`default_nettype wire

// ----- sv/utf8d_queue.sv -----
// two-entry queue of completed sequences between front and back
`default_nettype none
module utf8d_queue
    import utf8d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_seq i_seq,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_seq      o_head
);

    t_seq       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_seq;
        end
    end

endmodule
`default_nettype wire

// ----- sv/utf8d_back.sv -----
// back: forms the code point, applies replacement and holds result words
`default_nettype none
module utf8d_back
    import utf8d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_seq_valid,
    input  wire t_seq i_seq,
    output logic      o_seq_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_word o_out_word
);

    t_out_word   r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic [31:0] diff;
    t_out_word   res;
    logic        do_pop;

    assign do_pop    = i_pop && !o_empty;
    assign o_seq_pop = i_seq_valid && (r_count != 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_out_word = r_mem[r_rptr];
    assign diff      = i_seq.acc - len_offset(i_seq.len_idx);

    always_comb begin
        res.buffer_end = i_seq.eob;
        res.code_point = 21'd0;
        res.status     = ST_OK;
        case (i_seq.kind)
            K_ILLEGAL: res.status = ST_ILLEGAL;
            K_TRUNC:   res.status = ST_TRUNC;
            K_DECODE: begin
                if (diff > MAX_SCALAR) begin
                    res.code_point = REPLACEMENT;
                    res.status     = ST_RANGE;
                end else if ((diff >= SUR_LO) && (diff <= SUR_HI)) begin
                    if (i_seq.strict) begin
                        res.status = ST_ILLEGAL;
                    end else begin
                        res.code_point = REPLACEMENT;
                        res.status     = ST_SURR;
                    end
                end else begin
                    res.code_point = diff[20:0];
                end
            end
            default: res.status = ST_ILLEGAL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (o_seq_pop) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({o_seq_pop, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_seq_pop) begin
            r_mem[r_wptr] <= res;
        end
    end

endmodule
`default_nettype wire

// ----- sv/utf8_to_utf32_decoder_core.sv -----
// top level: utf-8 byte stream to utf-32 code point decoder
//
// channel   direction  handshake                 word
// input     in         push / full               i_in_word  (data_byte, end_of_buffer)
// result    out        empty / pop               o_out_word (code_point, status, buffer_end)
// config    in         i_cfg_we / i_cfg_wdata    strict_mode, no read-back
//
// one byte per cycle while full is low; front gathers each accepted byte, the sequence
// is registered in the sequence queue and back forms the word from the queue head
// a two-word sequence queue and a two-word result queue decouple the stages
// full rises only when the sequence queue holds two words; synchronous active-low reset
`default_nettype none
module utf8_to_utf32_decoder_core
    import utf8d_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     push,
    input  wire t_in_word i_in_word,
    output logic          full,
    output logic          empty,
    input  wire logic     pop,
    output t_out_word     o_out_word
);

    logic accept;
    logic seq_push, seq_pop, seq_valid;
    t_seq seq_in, seq_head;

    assign accept = push && !full;

    utf8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (accept),
        .i_in_word  (i_in_word),
        .o_seq_push (seq_push),
        .o_seq      (seq_in)
    );

    utf8d_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (seq_push),
        .i_seq  (seq_in),
        .i_pop  (seq_pop),
        .o_full (full),
        .o_valid(seq_valid),
        .o_head (seq_head)
    );

    utf8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seq_valid(seq_valid),
        .i_seq      (seq_head),
        .o_seq_pop  (seq_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

endmodule
`default_nettype wire

// ----- sv/utf8d_checker.sv -----
// checker: port-level assertions for the decoder, bound to the top level
`default_nettype none
module utf8d_checker
    import utf8d_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_word o_out_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_word)))
        else $error("result word changed while waiting");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_word.status <= ST_TRUNC))
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_out_word.status == ST_ILLEGAL) || (o_out_word.status == ST_TRUNC)))
        |-> (o_out_word.code_point == 21'd0))
        else $error("error word with nonzero code point");

    a_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_out_word.status == ST_SURR) || (o_out_word.status == ST_RANGE)))
        |-> (o_out_word.code_point == REPLACEMENT))
        else $error("replaced word without replacement character");

    a_trunc_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_word.status == ST_TRUNC)) |-> o_out_word.buffer_end)
        else $error("truncation reported away from buffer end");

endmodule

bind utf8_to_utf32_decoder_core utf8d_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .empty     (empty),
    .pop       (pop),
    .o_out_word(o_out_word)
);
`default_nettype wire

// ----- test/utf8_to_utf32_decoder_core_test.sv -----
// testbench: random and directed utf-8 byte streams checked word by word against a decode tracker
`timescale 1ns / 1ps
module utf8_to_utf32_decoder_core_test
    import utf8d_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;

    class decode_tracker;
        logic [7:0] held_bytes [6];
        logic [2:0] seq_len;
        logic [2:0] seq_have;
        bit         stopped;
        bit         strict;
        t_out_word  points_due [$];
        int         errors;
        int         checked;
        int         by_status [5];

        function new();
            foreach (held_bytes[i]) held_bytes[i] = 8'h00;
            foreach (by_status[i]) by_status[i] = 0;
            seq_len  = 3'd0;
            seq_have = 3'd0;
            stopped  = 1'b0;
            strict   = 1'b1;
            errors   = 0;
            checked  = 0;
        endfunction

        static function logic [2:0] lead_length(logic [7:0] b);
            if (b < 8'hC0) return 3'd1;
            if (b < 8'hE0) return 3'd2;
            if (b < 8'hF0) return 3'd3;
            if (b < 8'hF8) return 3'd4;
            if (b < 8'hFC) return 3'd5;
            return 3'd6;
        endfunction

        function logic [31:0] length_offset(int n);
            case (n)
                2: return 32'h00003080;
                3: return 32'h000E2080;
                4: return 32'h03C82080;
                5: return 32'hFA082080;
                6: return 32'h82082080;
                default: return 32'h00000000;
            endcase
        endfunction

        function bit well_formed(int n);
            logic [7:0] lead;
            logic [7:0] second;
            int i;
            lead = held_bytes[0];
            if (n < 1 || n > 4) return 1'b0;
            if (lead >= 8'h80 && lead < 8'hC2) return 1'b0;
            if (lead > 8'hF4) return 1'b0;
            if (n >= 2) begin
                for (i = 2; i < n; i++) begin
                    if (held_bytes[i] < 8'h80 || held_bytes[i] > 8'hBF) return 1'b0;
                end
                second = held_bytes[1];
                if (second > 8'hBF) return 1'b0;
                case (lead)
                    8'hE0: if (second < 8'hA0) return 1'b0;
                    8'hED: if (second > 8'h9F) return 1'b0;
                    8'hF0: if (second < 8'h90) return 1'b0;
                    8'hF4: if (second > 8'h8F) return 1'b0;
                    default: if (second < 8'h80) return 1'b0;
                endcase
            end
            return 1'b1;
        endfunction

        function void queue_point(logic [20:0] cp, logic [2:0] st, logic eob);
            t_out_word w;
            w.code_point = cp;
            w.status     = st;
            w.buffer_end = eob;
            points_due.push_back(w);
        endfunction

        // returns 0 when the byte is dropped while halted
        function bit take_byte(t_in_word w);
            logic [31:0] acc;
            logic        eob;
            int          n;
            int          i;
            eob = w.end_of_buffer;
            if (stopped) begin
                if (eob) begin
                    stopped  = 1'b0;
                    seq_have = 3'd0;
                    seq_len  = 3'd0;
                end
                return 1'b0;
            end
            if (seq_have == 3'd0 || seq_have >= 3'd6 || seq_have >= seq_len) begin
                held_bytes[0] = w.data_byte;
                seq_len       = lead_length(w.data_byte);
                seq_have      = 3'd1;
            end else begin
                held_bytes[seq_have] = w.data_byte;
                seq_have++;
            end
            if (seq_have < seq_len) begin
                if (eob) begin
                    seq_have = 3'd0;
                    seq_len  = 3'd0;
                    queue_point(21'd0, ST_TRUNC, 1'b1);
                end
                return 1'b1;
            end
            n        = seq_len;
            seq_have = 3'd0;
            seq_len  = 3'd0;
            if (strict && !well_formed(n)) begin
                stopped = !eob;
                queue_point(21'd0, ST_ILLEGAL, eob);
                return 1'b1;
            end
            acc = 32'd0;
            for (i = 0; i < n; i++) begin
                acc = acc + {24'd0, held_bytes[i]};
                if (i + 1 < n) acc = acc << 6;
            end
            acc = acc - length_offset(n);
            if (acc > MAX_SCALAR) begin
                queue_point(REPLACEMENT, ST_RANGE, eob);
            end else if (acc >= SUR_LO && acc <= SUR_HI) begin
                if (strict) begin
                    stopped = !eob;
                    queue_point(21'd0, ST_ILLEGAL, eob);
                end else begin
                    queue_point(REPLACEMENT, ST_SURR, eob);
                end
            end else begin
                queue_point(acc[20:0], ST_OK, eob);
            end
            return 1'b1;
        endfunction

        function int pending();
            return points_due.size();
        endfunction

        task report_mismatch(string what);
            if (errors < 50) $display("error at word %0d: %s", checked, what);
            errors++;
        endtask

        task check_point(t_out_word got);
            t_out_word want;
            if (points_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word cp=%h status=%0d end=%0b",
                    got.code_point, got.status, got.buffer_end));
                return;
            end
            want = points_due.pop_front();
            if (got.code_point !== want.code_point)
                report_mismatch($sformatf("code_point %h, want %h",
                    got.code_point, want.code_point));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.buffer_end !== want.buffer_end)
                report_mismatch($sformatf("buffer_end %0b, want %0b",
                    got.buffer_end, want.buffer_end));
            if (want.status <= ST_TRUNC) by_status[want.status]++;
            checked++;
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      push        = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      pop         = 1'b0;
    logic      full;
    logic      empty;
    t_out_word o_out_word;

    decode_tracker tracker;
    int give_idle_pct = 0;
    int take_idle_pct = 0;
    int hold_req      = 0;
    int counted       = 0;
    int sent          = 0;
    int cycle_count   = 0;

    utf8_to_utf32_decoder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .i_in_word  (i_in_word),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("utf8_to_utf32_decoder_core: mismatch");
            $finish;
        end
    end

    // result side: random pops, with a long hold when requested
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) tracker.check_point(o_out_word);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    // push stays high after the accepting edge; the next call decides
    task automatic send_word(input logic [7:0] b, input logic eob);
        t_in_word w;
        w.data_byte     = b;
        w.end_of_buffer = eob;
        while ($urandom_range(99) < give_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (full);
        sent++;
        if (tracker.take_byte(w)) counted++;
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic strict_on);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= strict_on;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.strict = strict_on;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    function automatic logic [7:0] second_byte(logic [7:0] lead);
        case (lead)
            8'hE0: return 8'($urandom_range(8'hBF, 8'hA0));
            8'hED: return 8'($urandom_range(8'h9F, 8'h80));
            8'hF0: return 8'($urandom_range(8'hBF, 8'h90));
            8'hF4: return 8'($urandom_range(8'h8F, 8'h80));
            default: return cont_byte();
        endcase
    endfunction

    task automatic send_random_run();
        logic [7:0] run [$];
        logic [7:0] lead;
        logic       closes;
        int         pick;
        int         len;
        int         i;
        pick   = $urandom_range(99);
        closes = ($urandom_range(7) == 0);
        if (pick < 28) begin
            run.push_back(8'($urandom_range(8'h7F)));
        end else if (pick < 70) begin
            // well-formed multi-byte sequence
            if (pick < 44) lead = 8'($urandom_range(8'hDF, 8'hC2));
            else if (pick < 58) lead = 8'($urandom_range(8'hEF, 8'hE0));
            else lead = 8'($urandom_range(8'hF4, 8'hF0));
            len = decode_tracker::lead_length(lead);
            run.push_back(lead);
            run.push_back(second_byte(lead));
            for (i = 2; i < len; i++) run.push_back(cont_byte());
        end else if (pick < 80) begin
            // full-length but possibly overlong, surrogate, out of range or legacy
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(3))
                    0: lead = 8'hED;
                    1: lead = 8'hF4;
                    2: lead = 8'hE0;
                    default: lead = 8'hF0;
                endcase
            end else begin
                lead = 8'($urandom_range(8'hFF, 8'h80));
            end
            len = decode_tracker::lead_length(lead);
            run.push_back(lead);
            for (i = 1; i < len; i++)
                run.push_back(($urandom_range(99) < 85) ? cont_byte() : 8'($urandom_range(255)));
        end else if (pick < 90) begin
            // buffer ends inside a sequence
            lead = 8'($urandom_range(8'hFF, 8'hC0));
            len  = decode_tracker::lead_length(lead);
            run.push_back(lead);
            len = $urandom_range(len - 2);
            for (i = 0; i < len; i++) run.push_back(cont_byte());
            closes = 1'b1;
        end else begin
            len = $urandom_range(3, 1);
            for (i = 0; i < len; i++) run.push_back(8'($urandom_range(255)));
        end
        for (i = 0; i < run.size(); i++)
            send_word(run[i], closes && (i == run.size() - 1));
    endtask

    initial begin : stimulus
        int blk;
        int goal;
        tracker = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        give_idle_pct = 16;
        take_idle_pct = 69;

        // strict mode after reset
        send_word(8'h00, 1'b0);
        send_word(8'hC2, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hF4, 1'b0);
        send_word(8'h8F, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hE2, 1'b0);
        send_word(8'h82, 1'b1);
        send_word(8'h80, 1'b1);
        send_word(8'hC0, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'h7F, 1'b1);

        // lenient: surrogate, above range, legacy six-byte form
        write_mode(1'b0);
        send_word(8'hED, 1'b0);
        send_word(8'hA0, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hF4, 1'b0);
        send_word(8'h90, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b1);

        for (blk = 0; blk < 6; blk++) begin
            if (blk == 2) begin
                give_idle_pct = 69;
                take_idle_pct = 16;
            end else if (blk == 4) begin
                give_idle_pct = 0;
                take_idle_pct = 0;
            end
            // leave a sequence open across the mode write
            send_word(8'hF0, 1'b0);
            write_mode(blk % 2 == 0);
            if (blk == 0) hold_req = 400;
            goal = counted + 100;
            while (counted < goal) send_random_run();
        end

        drain_and_settle();
        repeat (8) @(posedge i_clk);
        $display("%0d bytes sent, %0d decoded and %0d dropped while halted; %0d words checked",
            sent, counted, sent - counted, tracker.checked);
        $display("by status: ok %0d, surrogate %0d, range %0d, illegal %0d, truncated %0d",
            tracker.by_status[ST_OK], tracker.by_status[ST_SURR], tracker.by_status[ST_RANGE],
            tracker.by_status[ST_ILLEGAL], tracker.by_status[ST_TRUNC]);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("utf8_to_utf32_decoder_core: match");
        end else begin
            $display("utf8_to_utf32_decoder_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/utf8d_pkg.sv
sv/utf8d_front.sv
sv/utf8d_queue.sv
sv/utf8d_back.sv
sv/utf8_to_utf32_decoder_core.sv
sv/utf8d_checker.sv
test/utf8_to_utf32_decoder_core_test.sv
